>>> rtl/ira_pkg.sv
// Shared constants, types and helper functions for the integer to radix ASCII converter.
package ira_pkg;

  // Width of the input integer word.
  localparam int VALUE_BITS  = 32;
  // The magnitude is divided one hex nibble at a time, so it is padded to whole nibbles.
  localparam int NIB_CNT     = (VALUE_BITS + 3) / 4;
  localparam int WORD_BITS   = NIB_CNT * 4;
  localparam int NIB_W       = (NIB_CNT > 1) ? $clog2(NIB_CNT) : 1;
  // Radix 2 gives the longest text: one digit per value bit.
  localparam int DIGIT_DEPTH = VALUE_BITS;
  localparam int ADDR_W      = $clog2(DIGIT_DEPTH);
  localparam int CNT_W       = $clog2(DIGIT_DEPTH + 1);

  localparam int BASE_W      = 5;
  localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] ASCII_A_OFF = 8'h57;  // 'a' minus ten
  localparam logic [7:0] ASCII_MINUS = 8'h2d;  // '-'

  // Control lines from the sequencer to the digit stack.
  typedef struct packed {
    logic clr;
    logic push;
    logic pop;
  } stk_ctl_t;

  // Map a digit value 0..15 to its lower-case ASCII character.
  function automatic logic [7:0] digit_ascii(input logic [3:0] d);
    logic [7:0] d8;
    d8 = {4'd0, d};
    if (d < 4'd10) begin
      digit_ascii = ASCII_ZERO + d8;
    end else begin
      digit_ascii = ASCII_A_OFF + d8;
    end
  endfunction

endpackage

>>> rtl/ira_div.sv
// Shared divide unit: one nibble of long division by the radix per call.
module ira_div (
  input  logic [3:0]                  rem_in,
  input  logic [3:0]                  nib_in,
  input  logic [ira_pkg::BASE_W-1:0]  base,
  output logic [3:0]                  quo_out,
  output logic [3:0]                  rem_out
);
  import ira_pkg::*;

  // Four restoring steps; the partial remainder stays below the radix, so five bits suffice.
  always_comb begin
    logic [4:0] r;
    r = {1'b0, rem_in};
    quo_out = 4'd0;
    for (int i = 3; i >= 0; i--) begin
      r = {r[3:0], nib_in[i]};
      if (r >= base) begin
        r = r - base;
        quo_out[i] = 1'b1;
      end
    end
    rem_out = r[3:0];
  end

endmodule

>>> rtl/ira_stack.sv
// Digit stack: remainders are pushed least significant first and popped in reverse.
module ira_stack (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ira_pkg::stk_ctl_t          ctl,
  input  logic [3:0]                 din,
  output logic [3:0]                 top,
  output logic [ira_pkg::CNT_W-1:0]  cnt
);
  import ira_pkg::*;

  logic [3:0]       mem_r [DIGIT_DEPTH];
  logic [3:0]       top_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_m2;

  assign cnt_m1 = cnt_r - 1'b1;
  assign cnt_m2 = cnt_r - 2'd2;
  assign top    = top_r;
  assign cnt    = cnt_r;

  // Fill level; clear takes priority since it starts a new number.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.clr) begin
      cnt_r <= '0;
    end else if (ctl.push) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (ctl.pop) begin
      cnt_r <= cnt_m1;
    end
  end

  // Digit storage needs no reset; only filled entries are ever used.
  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.clr) begin
      mem_r[cnt_r[ADDR_W-1:0]] <= din;
    end
  end

  // The top entry is kept in a register: a push writes it directly, a pop fetches the one below.
  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.clr) begin
      top_r <= din;
    end else if (ctl.pop) begin
      top_r <= mem_r[cnt_m2[ADDR_W-1:0]];
    end
  end

endmodule

>>> rtl/integer_to_radix_ascii.sv
// Top level of the integer to radix ASCII converter: sequencer, output register and checks.
//
// Each accepted word is converted by repeated division of its magnitude by the radix, using
// one shared divide unit that handles one hex nibble per cycle, so every digit takes a pass
// over all NIB_CNT nibbles (8 for 32-bit words). The digits are then popped from a stack, one
// character per cycle when the output is not stalled, with a leading '-' for negative
// signed values. The input is ready only while the sequencer is idle; it becomes idle as
// soon as the last character is loaded into the output register, so the next word can
// start while that character still waits. A radix outside 2..16 is treated as 16.
module integer_to_radix_ascii (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ira_pkg::VALUE_BITS-1:0] in_value,
  input  logic [ira_pkg::BASE_W-1:0]     in_base,
  input  logic                           in_is_signed,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_character,
  output logic                           out_last
);
  import ira_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [WORD_BITS-1:0] quo_r, quo_nxt;
  logic [3:0]           rem_r, rem_nxt;
  logic [BASE_W-1:0]    base_r, base_nxt;
  logic [NIB_W-1:0]     nib_r, nib_nxt;
  logic                 neg_r, neg_nxt;
  logic                 minus_pend_r, minus_pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                  in_fire;
  logic                  load;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;
  logic [3:0]            div_quo;
  logic [3:0]            div_rem;
  logic [WORD_BITS-1:0]  quo_shift;
  logic [3:0]            stk_top;
  logic [CNT_W-1:0]      stk_cnt;
  stk_ctl_t              stk_ctl;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign load      = !out_valid_r || out_ready;
  assign in_neg    = in_is_signed && in_value[VALUE_BITS-1];
  assign in_mag    = in_neg ? (~in_value + 1'b1) : in_value;
  assign quo_shift = {quo_r[WORD_BITS-5:0], div_quo};

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  ira_div u_div (
    .rem_in  (rem_r),
    .nib_in  (quo_r[WORD_BITS-1 -: 4]),
    .base    (base_r),
    .quo_out (div_quo),
    .rem_out (div_rem)
  );

  ira_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (stk_ctl),
    .din   (div_rem),
    .top   (stk_top),
    .cnt   (stk_cnt)
  );

  // Sequencer: divide nibble by nibble until the quotient is zero, then unload the stack.
  always_comb begin
    state_nxt      = state_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    base_nxt       = base_r;
    nib_nxt        = nib_r;
    neg_nxt        = neg_r;
    minus_pend_nxt = minus_pend_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    stk_ctl        = '{clr: 1'b0, push: 1'b0, pop: 1'b0};

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          quo_nxt     = WORD_BITS'(in_mag);
          rem_nxt     = 4'd0;
          nib_nxt     = '0;
          neg_nxt     = in_neg;
          base_nxt    = (in_base < BASE_MIN || in_base > BASE_MAX) ? BASE_MAX : in_base;
          stk_ctl.clr = 1'b1;
          state_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_nxt = quo_shift;
        rem_nxt = div_rem;
        nib_nxt = nib_r + 1'b1;
        // The last nibble of a pass yields one digit; zero still yields a single digit.
        if (nib_r == NIB_W'(NIB_CNT - 1)) begin
          stk_ctl.push = 1'b1;
          rem_nxt      = 4'd0;
          nib_nxt      = '0;
          if (quo_shift == '0) begin
            minus_pend_nxt = neg_r;
            state_nxt      = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          if (minus_pend_r) begin
            out_char_nxt   = ASCII_MINUS;
            out_last_nxt   = 1'b0;
            minus_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = digit_ascii(stk_top);
            out_last_nxt = (stk_cnt == CNT_W'(1));
            stk_ctl.pop  = 1'b1;
            if (stk_cnt == CNT_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      minus_pend_r <= 1'b0;
      nib_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      minus_pend_r <= minus_pend_nxt;
      nib_r        <= nib_nxt;
    end
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    base_r     <= base_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // The stack never holds more digits than a radix-2 conversion produces.
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stk_cnt <= CNT_W'(DIGIT_DEPTH))
    else $error("digit stack overflow");

  // The running remainder always stays below the radix while dividing.
  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < base_r))
    else $error("remainder not below radix");

  // An accepted word blocks further input on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input ready right after accept");

  // A minus sign never ends the text of a number.
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_char_r == ASCII_MINUS) |-> !out_last_r)
    else $error("minus sign marked as last character");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the integer to radix ASCII converter.
`timescale 1ns / 1ps

module tb_top;

  import ira_pkg::*;

  localparam int VB         = ira_pkg::VALUE_BITS;
  localparam int CYCLE_CAP  = 1200000;
  localparam int DRAIN_WAIT = 400;
  localparam int RAND_WORDS = 410;

  // One character of expected number text.
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  // Predicts the text of each accepted word and checks the characters that come out.
  class radix_text_board;
    text_char_t expected_text[$];
    int         mismatch_count;
    int         char_index;

    function new();
      mismatch_count = 0;
      char_index     = 0;
    endfunction

    task report(string what);
      $display("mismatch at character %0d: %s", char_index, what);
      mismatch_count++;
    endtask

    // Work out the characters one accepted word must produce.
    function void note_word(logic [VB-1:0] v, logic [BASE_W-1:0] b, logic sgn);
      string       digit_set;
      logic [VB:0] mag;
      logic [7:0]  digs[VB+1];
      int          nd;
      int unsigned radix;
      bit          neg;
      text_char_t  tc;
      digit_set = "0123456789abcdef";
      nd        = 0;
      radix     = 32'(b);
      if (radix < 2 || radix > 16) begin
        radix = 16;
      end
      // Zero is a single '0' in either mode.
      if (v == '0) begin
        tc.ch   = "0";
        tc.last = 1'b1;
        expected_text.push_back(tc);
        return;
      end
      neg = sgn && v[VB-1];
      // The magnitude is one bit wider, so the most negative value converts exactly.
      mag = neg ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
      while (mag != '0) begin
        digs[nd] = digit_set[int'(mag % radix)];
        mag      = mag / radix;
        nd++;
      end
      if (neg) begin
        tc.ch   = "-";
        tc.last = 1'b0;
        expected_text.push_back(tc);
      end
      for (int k = nd - 1; k >= 0; k--) begin
        tc.ch   = digs[k];
        tc.last = (k == 0);
        expected_text.push_back(tc);
      end
    endfunction

    // Compare one delivered character with the oldest expected one.
    task check_char(logic [7:0] ch, logic last);
      text_char_t tc;
      if (expected_text.size() == 0) begin
        report($sformatf("unexpected character 0x%02h last=%0b", ch, last));
      end else begin
        tc = expected_text.pop_front();
        if (ch !== tc.ch) begin
          report($sformatf("character 0x%02h, expected 0x%02h", ch, tc.ch));
        end
        if (last !== tc.last) begin
          report($sformatf("last %0b, expected %0b", last, tc.last));
        end
      end
      char_index++;
    endtask

    function int pending();
      return expected_text.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [VB-1:0]        in_value;
  logic [BASE_W-1:0]    in_base;
  logic                 in_is_signed;
  logic                 out_valid;
  logic                 out_ready;
  logic [7:0]           out_character;
  logic                 out_last;

  radix_text_board board;
  int              cycles;
  int              burst_left;

  integer_to_radix_ascii DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .in_base      (in_base),
    .in_is_signed (in_is_signed),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_character(out_character),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Present one word and hold it until the block takes it.
  task send_word(logic [VB-1:0] v, logic [BASE_W-1:0] b, logic sgn);
    @(negedge clk);
    in_valid     <= 1'b1;
    in_value     <= v;
    in_base      <= b;
    in_is_signed <= sgn;
    do begin
      @(posedge clk);
    end while (!in_ready);
    board.note_word(v, b, sgn);
  endtask

  // Leave the input idle for a number of cycles with junk on the payload.
  task idle_input(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid     <= 1'b0;
      in_value     <= $urandom;
      in_base      <= BASE_W'($urandom);
      in_is_signed <= 1'($urandom);
    end
  endtask

  // Random sender bursts: after each burst comes a short gap.
  task paced_send(logic [VB-1:0] v, logic [BASE_W-1:0] b, logic sgn);
    if (burst_left == 0) begin
      idle_input($urandom_range(1, 7));
      burst_left = $urandom_range(1, 8);
    end
    send_word(v, b, sgn);
    burst_left--;
  endtask

  // Values lean toward the edges of the word as well as fully random ones.
  function automatic logic [VB-1:0] pick_value();
    logic [VB-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4:          v = $urandom_range(0, 40);
      5:          v = {VB{1'b1}} - $urandom_range(0, 20);
      6:          v = {1'b1, {(VB-1){1'b0}}} + $urandom_range(0, 20);
      7:          v = {1'b0, {(VB-1){1'b1}}} - $urandom_range(0, 20);
      8:          v = {{(VB-1){1'b0}}, 1'b1} << $urandom_range(0, VB - 1);
      default:    v = $urandom >> $urandom_range(0, VB - 1);
    endcase
    return v;
  endfunction

  // Mostly legal radixes, with the occasional out-of-range one.
  function automatic logic [BASE_W-1:0] pick_base();
    if ($urandom_range(0, 99) < 85) begin
      return BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
    end
    return BASE_W'($urandom_range(0, 31));
  endfunction

  // Receiver: switches between always ready, random, sparse and fixed on/off patterns.
  initial begin
    int mode;
    int span;
    int on_len;
    int off_len;
    int phase;
    out_ready = 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      span    = $urandom_range(20, 200);
      on_len  = $urandom_range(1, 4);
      off_len = $urandom_range(1, 5);
      phase   = 0;
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 1);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (phase < on_len);
        endcase
        phase = (phase + 1) % (on_len + off_len);
      end
    end
  end

  // Every delivered character on the result side is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_char(out_character, out_last);
    end
  end

  // Guard against a hung run.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_CAP) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    board        = new();
    burst_left   = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_value     = '0;
    in_base      = BASE_MIN;
    in_is_signed = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every legal radix on a mixed word, alternating the sign mode.
    for (int b = BASE_MIN; b <= BASE_MAX; b++) begin
      paced_send({VB{1'b1}} ^ 32'h01234567, BASE_W'(b), b[0]);
    end
    // Out-of-range radixes fall back to sixteen.
    paced_send(32'h12345678, 5'd0, 1'b0);
    paced_send(32'h12345678, 5'd1, 1'b1);
    paced_send(32'h12345678, 5'd17, 1'b0);
    paced_send(32'h9abcdef0, 5'd31, 1'b1);
    // Zero in both modes, the all-ones word, the most negative and the largest positive value.
    paced_send('0, 5'd10, 1'b0);
    paced_send('0, 5'd31, 1'b1);
    paced_send({VB{1'b1}}, 5'd2, 1'b0);
    paced_send({VB{1'b1}}, 5'd16, 1'b1);
    paced_send({1'b1, {(VB-1){1'b0}}}, 5'd10, 1'b1);
    paced_send({1'b1, {(VB-1){1'b0}}}, 5'd2, 1'b1);
    paced_send({1'b0, {(VB-1){1'b1}}}, 5'd10, 1'b1);

    // Random words; now and then a long stretch with no sender gaps.
    for (int i = 0; i < RAND_WORDS; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        burst_left = $urandom_range(10, 30);
      end
      paced_send(pick_value(), pick_base(), 1'($urandom_range(0, 1)));
    end
    idle_input(1);

    while (board.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    if (board.mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
